@@ rtl/lphm_pkg.sv @@
// shared types, constants and hash helpers for the linear probe hash map
package lphm_pkg;

  localparam int TableSizeDefault = 1024;
  localparam logic [31:0] HashMul = 32'h045d9f3b;
  localparam int HashShift = 16;

  localparam logic [1:0] MODE_PUT    = 2'd0;
  localparam logic [1:0] MODE_GET    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_BAD    = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
  } out_item_t;

  function automatic logic [31:0] xs_fold(input logic [31:0] x);
    xs_fold = (x >> HashShift) ^ x;
  endfunction

endpackage

@@ rtl/lphm_front.sv @@
// front end: accepts items, hashes the key and queues jobs with their start slot
module lphm_front #(
  parameter int TABLE_SIZE = lphm_pkg::TableSizeDefault,
  parameter int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lphm_pkg::in_item_t   in_data,
  output logic                 job_valid,
  input  logic                 job_take,
  output lphm_pkg::in_item_t   job_item,
  output logic [IW-1:0]        job_start
);

  // floor(2^32 / TABLE_SIZE): quotient estimate is low by at most one
  localparam logic [31:0] Recip = 32'((64'd1 << 32) / 64'(TABLE_SIZE));

  // hash pipe: fold, mul, fold, mul, fold, quotient, remainder, correct
  logic [2:0]          stg_r, stg_nxt;
  logic                busy_r, busy_nxt;
  lphm_pkg::in_item_t  item_r;
  logic [31:0]         h_r, h_nxt;
  logic [31:0]         q_r, q_nxt;

  // two-entry queue
  lphm_pkg::in_item_t  q_item_r [2];
  logic [IW-1:0]       q_idx_r [2];
  logic                q_wp_r, q_rp_r;
  logic [1:0]          q_cnt_r;
  logic                push, pop;
  logic [31:0]         mul_b;
  logic [63:0]         prod;
  logic [IW-1:0]       start;

  assign mul_b = (stg_r == 3'd5) ? Recip : lphm_pkg::HashMul;
  assign prod  = 64'(h_r) * 64'(mul_b);
  // remainder is below twice the table size here, one subtract finishes it
  assign start = IW'((h_r >= 32'(TABLE_SIZE)) ? h_r - 32'(TABLE_SIZE) : h_r);

  assign in_stall  = busy_r;
  assign push      = busy_r && (stg_r == 3'd7) && (q_cnt_r != 2'd2);
  assign pop       = job_valid && job_take;
  assign job_valid = (q_cnt_r != 2'd0);
  assign job_item  = q_item_r[q_rp_r];
  assign job_start = q_idx_r[q_rp_r];

  always_comb begin
    busy_nxt = busy_r;
    stg_nxt  = stg_r;
    h_nxt    = h_r;
    q_nxt    = q_r;
    if (!busy_r) begin
      if (in_valid) begin
        busy_nxt = 1'b1;
        stg_nxt  = 3'd1;
        h_nxt    = lphm_pkg::xs_fold(in_data.key);
      end
    end else begin
      case (stg_r)
        3'd1: begin h_nxt = prod[31:0];               stg_nxt = 3'd2; end
        3'd2: begin h_nxt = lphm_pkg::xs_fold(h_r);   stg_nxt = 3'd3; end
        3'd3: begin h_nxt = prod[31:0];               stg_nxt = 3'd4; end
        3'd4: begin h_nxt = lphm_pkg::xs_fold(h_r);   stg_nxt = 3'd5; end
        3'd5: begin q_nxt = prod[63:32];              stg_nxt = 3'd6; end
        3'd6: begin
          h_nxt   = h_r - q_r * 32'(TABLE_SIZE);
          stg_nxt = 3'd7;
        end
        3'd7: begin
          if (push) busy_nxt = 1'b0;
        end
        default: stg_nxt = 3'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      stg_r   <= 3'd0;
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      stg_r  <= stg_nxt;
      if (push) q_wp_r <= ~q_wp_r;
      if (pop)  q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    q_r <= q_nxt;
    if (!busy_r && in_valid) item_r <= in_data;
    if (push) begin
      q_item_r[q_wp_r] <= item_r;
      q_idx_r[q_wp_r]  <= start;
    end
  end

`ifndef SYNTH
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n) q_cnt_r != 2'd3)
    else $error("job queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r == 2'd2 |-> !push)
    else $error("push into full job queue");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> busy_r && stg_r == 3'd1)
    else $error("hash pipe did not start");
`endif

endmodule

@@ rtl/lphm_back.sv @@
// back end: probes the slot memories and writes results
module lphm_back #(
  parameter int TABLE_SIZE = lphm_pkg::TableSizeDefault,
  parameter int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_take,
  input  lphm_pkg::in_item_t   job_item,
  input  logic [IW-1:0]        job_start,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lphm_pkg::out_item_t  out_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam int CW = $clog2(TABLE_SIZE + 1);

  logic [31:0] key_mem [TABLE_SIZE];
  logic [31:0] val_mem [TABLE_SIZE];
  logic [1:0]  flg_mem [TABLE_SIZE]; // {used, tombstone}

  logic [2:0]          st_r, st_nxt;
  logic [IW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  lphm_pkg::in_item_t  job_r;
  logic [31:0]         rk_r, rv_r;
  logic [1:0]          rf_r;
  lphm_pkg::out_item_t res_r, res_nxt;
  logic                ov_r, ov_nxt;
  logic                we_k, we_v, we_f;
  logic [1:0]          wf;
  logic                kmatch, stop_here;
  logic [IW-1:0]       pos_inc;

  assign job_take  = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = res_r;
  assign kmatch    = rk_r == job_r.key;
  assign pos_inc   = (pos_r == IW'(TABLE_SIZE - 1)) ? '0 : pos_r + 1'b1;

  always_comb begin
    st_nxt = st_r; pos_nxt = pos_r; cnt_nxt = cnt_r;
    res_nxt = res_r; ov_nxt = ov_r;
    we_k = 1'b0; we_v = 1'b0; we_f = 1'b0; wf = 2'b00;
    stop_here = 1'b0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      S_CLEAR: begin
        we_f = 1'b1;
        pos_nxt = pos_inc;
        if (pos_r == IW'(TABLE_SIZE - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (job_valid && !ov_r) begin
          pos_nxt = job_start;
          cnt_nxt = '0;
          st_nxt  = S_READ;
        end
      end
      S_READ: st_nxt = S_EVAL;
      S_EVAL: begin
        res_nxt.read_value = '0;
        if (job_r.mode == lphm_pkg::MODE_PUT) begin
          stop_here = !rf_r[1] || kmatch;
          if (stop_here) begin
            we_v = 1'b1; we_f = 1'b1; wf = 2'b10;
            we_k = !rf_r[1];
            res_nxt.status = lphm_pkg::ST_OK;
          end else res_nxt.status = lphm_pkg::ST_FULL;
        end else if (job_r.mode == lphm_pkg::MODE_GET ||
                     job_r.mode == lphm_pkg::MODE_REMOVE) begin
          stop_here = !rf_r[1] || (kmatch && !rf_r[0]);
          if (rf_r[1] && kmatch && !rf_r[0]) begin
            res_nxt.status = lphm_pkg::ST_OK;
            if (job_r.mode == lphm_pkg::MODE_GET) res_nxt.read_value = rv_r;
            else begin we_f = 1'b1; wf = 2'b11; end
          end else res_nxt.status = lphm_pkg::ST_ABSENT;
        end else begin
          stop_here = 1'b1;
          res_nxt.status = lphm_pkg::ST_ABSENT;
        end
        if (stop_here || cnt_r == CW'(TABLE_SIZE - 1)) begin
          st_nxt = S_OUT;
        end else begin
          pos_nxt = pos_inc;
          cnt_nxt = cnt_r + 1'b1;
          st_nxt  = S_READ;
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLEAR;
      pos_r <= '0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (job_take && job_valid) job_r <= job_item;
    rk_r <= key_mem[pos_r];
    rv_r <= val_mem[pos_r];
    rf_r <= flg_mem[pos_r];
    if (we_k) key_mem[pos_r] <= job_r.key;
    if (we_v) val_mem[pos_r] <= job_r.value;
    if (we_f) flg_mem[pos_r] <= wf;
  end

`ifndef SYNTH
  a_out_from_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(st_r) == S_OUT)
    else $error("result raised outside output step");
  a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_CLEAR |-> !job_take)
    else $error("job taken during clearing pass");
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_SIZE - 1))
    else $error("probe count past table size");
`endif

endmodule

@@ rtl/linear_probe_hash_map_core.sv @@
// top level of the linear probe hash map
// usage:
//  - input channel in_valid/in_stall/in_data carries put, get or remove with
//    key and value; output channel out_valid/out_stall/out_data returns one
//    status and read value per transaction, in order
//  - a front hash pipe works on one transaction at a time (two xor-shift-multiply
//    rounds, a reciprocal multiply and subtract for the modulo, one corrective
//    subtract) and feeds a two-entry job queue; in_stall is high while the
//    pipe is busy or its finished job waits for queue room
//  - the back end takes a job, then probes the slot memories one slot at a time
//    (registered memory read, then compare and write), then hands off the
//    result
//  - front and back end work concurrently through the queue; throughput is
//    set by the slower of the two, and the back end slows with each extra probe
//  - after reset the back end clears the used and tombstone flags, one slot
//    per cycle, over all TABLE_SIZE slots; items queue in front meanwhile
//  - while out_stall is high a pending result holds and the back end stops
//    taking jobs; the front keeps hashing into the queue until it fills
module linear_probe_hash_map_core #(
  parameter int TABLE_SIZE = lphm_pkg::TableSizeDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lphm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lphm_pkg::out_item_t  out_data
);

  localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  logic               job_valid, job_take;
  lphm_pkg::in_item_t job_item;
  logic [IW-1:0]      job_start;

  lphm_front #(.TABLE_SIZE(TABLE_SIZE), .IW(IW)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .job_valid, .job_take, .job_item, .job_start
  );

  lphm_back #(.TABLE_SIZE(TABLE_SIZE), .IW(IW)) u_back (
    .clk, .rst_n, .job_valid, .job_take, .job_item, .job_start,
    .out_valid, .out_stall, .out_data
  );

endmodule

@@ tb/hash_map_checker.sv @@
// checker for the linear probe hash map: watches both channels, predicts and compares
`timescale 1ns / 100ps
module hash_map_checker #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  lphm_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  lphm_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);

  logic [31:0] tbl_key [TABLE_SIZE];
  logic [31:0] tbl_val [TABLE_SIZE];
  bit          tbl_used [TABLE_SIZE];
  bit          tbl_dead [TABLE_SIZE];
  lphm_pkg::out_item_t expected_q[$];

  function automatic int home_slot(logic [31:0] k);
    logic [31:0] x;
    x = k;
    x = ((x >> 16) ^ x) * lphm_pkg::HashMul;
    x = ((x >> 16) ^ x) * lphm_pkg::HashMul;
    x = (x >> 16) ^ x;
    return int'(x % TABLE_SIZE);
  endfunction

  // returns slot index or -1 when the probe runs out
  function automatic int find_slot(logic [31:0] k, bit take_dead);
    int p;
    p = home_slot(k);
    for (int n = 0; n < TABLE_SIZE; n++) begin
      if (!tbl_used[p]) return p;
      if (tbl_key[p] == k && (take_dead || !tbl_dead[p])) return p;
      p = (p + 1) % TABLE_SIZE;
    end
    return -1;
  endfunction

  function automatic lphm_pkg::out_item_t apply_op(lphm_pkg::in_item_t it);
    lphm_pkg::out_item_t r;
    int p;
    r.status = lphm_pkg::ST_ABSENT;
    r.read_value = '0;
    case (it.mode)
      lphm_pkg::MODE_PUT: begin
        p = find_slot(it.key, 1'b1);
        if (p < 0) begin
          r.status = lphm_pkg::ST_FULL;
        end else begin
          if (!tbl_used[p]) begin
            tbl_used[p] = 1'b1;
            tbl_key[p] = it.key;
          end
          tbl_val[p] = it.value;
          tbl_dead[p] = 1'b0;
          r.status = lphm_pkg::ST_OK;
        end
      end
      lphm_pkg::MODE_GET: begin
        p = find_slot(it.key, 1'b0);
        if (p >= 0 && tbl_used[p]) begin
          r.status = lphm_pkg::ST_OK;
          r.read_value = tbl_val[p];
        end
      end
      lphm_pkg::MODE_REMOVE: begin
        p = find_slot(it.key, 1'b0);
        if (p >= 0 && tbl_used[p]) begin
          tbl_dead[p] = 1'b1;
          r.status = lphm_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tbl_used[i] = 1'b0;
      tbl_dead[i] = 1'b0;
    end
  end

  always @(posedge clk) begin
    lphm_pkg::out_item_t exp_r;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_q.push_back(apply_op(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_data.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, out_data.status);
            fail_count++;
          end
          if (out_data.read_value !== exp_r.read_value) begin
            $error("read_value expected %h actual %h", exp_r.read_value,
                   out_data.read_value);
            fail_count++;
          end
        end
      end
      pending = expected_q.size();
    end
  end
endmodule

@@ tb/testbench.sv @@
// stimulus and verdict for the linear probe hash map core
`timescale 1ns / 100ps
module testbench;

  localparam int TABLE_SIZE = 1024;
  localparam int IdleLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  lphm_pkg::in_item_t in_data = '0;
  logic in_stall, out_valid;
  lphm_pkg::out_item_t out_data;
  int fail_count, pending;

  bit long_hold = 1'b0;
  int idle_cycles = 0;
  logic [31:0] key_pool[16];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  linear_probe_hash_map_core #(.TABLE_SIZE(TABLE_SIZE)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  hash_map_checker #(.TABLE_SIZE(TABLE_SIZE)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // offer one transaction, hold it until accepted
  task automatic send_op(logic [1:0] m, logic [31:0] k, logic [31:0] v);
    in_data.mode = m;
    in_data.key = k;
    in_data.value = v;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic go_idle(int n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // receiver stall pattern, with one long hold-off
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) out_stall = 1'b1;
      else if (($urandom_range(0, 63) < 8)) out_stall = 1'b0;
      else out_stall = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    @(posedge rst_n);
    repeat (2500) @(posedge clk);
    long_hold = 1'b1;
    repeat (400) @(posedge clk);
    long_hold = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int burst;
    int r;
    logic [31:0] k;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hffff_ffff;

    // directed: extremes, every mode, tombstone revival, unknown mode
    send_op(lphm_pkg::MODE_GET, 32'h0, 32'h0);
    send_op(lphm_pkg::MODE_PUT, 32'h0, 32'hffff_ffff);
    send_op(lphm_pkg::MODE_PUT, 32'hffff_ffff, 32'h0);
    send_op(lphm_pkg::MODE_GET, 32'h0, 32'h0);
    send_op(lphm_pkg::MODE_GET, 32'hffff_ffff, 32'hffff_ffff);
    send_op(lphm_pkg::MODE_PUT, 32'h0, 32'h1234_5678);
    send_op(lphm_pkg::MODE_GET, 32'h0, 32'h0);
    send_op(lphm_pkg::MODE_REMOVE, 32'h0, 32'h0);
    send_op(lphm_pkg::MODE_GET, 32'h0, 32'h0);
    send_op(lphm_pkg::MODE_REMOVE, 32'h0, 32'h0);
    send_op(lphm_pkg::MODE_PUT, 32'h0, 32'hdead_beef);
    send_op(lphm_pkg::MODE_GET, 32'h0, 32'h0);
    send_op(lphm_pkg::MODE_BAD, 32'hffff_ffff, 32'hffff_ffff);
    send_op(lphm_pkg::MODE_REMOVE, 32'h5555_aaaa, 32'h0);
    send_op(lphm_pkg::MODE_PUT, 32'haaaa_5555, 32'h5555_aaaa);
    send_op(lphm_pkg::MODE_GET, 32'haaaa_5555, 32'h0);

    // the sender pauses until every result has come
    go_idle(0);
    while (pending != 0) @(negedge clk);

    // random bursts; mostly a small key pool so hits, removes and revivals occur
    for (int i = 0; i < 1950; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && i < 1950; b++, i++) begin
        r = $urandom_range(0, 99);
        if (r < 75) k = key_pool[$urandom_range(0, 15)];
        else k = $urandom();
        r = $urandom_range(0, 99);
        send_op(r < 40 ? lphm_pkg::MODE_PUT : r < 75 ? lphm_pkg::MODE_GET :
                r < 97 ? lphm_pkg::MODE_REMOVE : lphm_pkg::MODE_BAD,
                k, $urandom());
      end
      if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 12));
    end
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/lphm_pkg.sv
rtl/lphm_front.sv
rtl/lphm_back.sv
rtl/linear_probe_hash_map_core.sv
tb/hash_map_checker.sv
tb/testbench.sv
